// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RPR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpr assertion failed");

// Next-cycle implication, checked out of reset.
`define RPR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpr assertion failed");

`endif

// ===== rtl/core/rpr_pkg.sv =====
// Shared types and constants of the rounded panel rasterizer.
`default_nettype none

package rpr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIM_CFG_W  = 12;
    localparam int RADIUS_W   = 13;
    localparam int BORDER_W   = 12;
    localparam int RGB_W      = 24;
    localparam int CH_W       = 8;

    localparam logic [DIM_CFG_W-1:0] FRAME_DIM_RST = 12'd64;
    localparam logic [CH_W-1:0]      ALPHA_OPAQUE  = 8'hFF;
    localparam logic [CH_W-1:0]      ALPHA_CLEAR   = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_RADIUS_HALF  = 3'd2,
        CFG_BORDER_PX    = 3'd3,
        CFG_FILL_RGB     = 3'd4,
        CFG_BORDER_RGB   = 3'd5
    } cfg_reg_t;

    // Per-pixel geometry flags carried down the pipe
    typedef struct packed {
        logic dx_zero;
        logic dy_zero;
        logic near_edge;
        logic last;
    } pix_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpr_scan.sv =====
// Raster scan position counter and first pipeline register.
`default_nettype none
`include "assert_macros.svh"

module rpr_scan #(
    parameter int POS_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             restart,
    input  logic [POS_W:0]   w_eff,
    input  logic [POS_W:0]   h_eff,
    output logic [POS_W-1:0] x,
    output logic [POS_W-1:0] y
);
    import rpr_pkg::*;

    localparam int CNT_W = POS_W + 1;

    logic [POS_W-1:0] scan_col_reg;
    logic [POS_W-1:0] scan_row_reg;
    logic [POS_W-1:0] scan_col_next;
    logic [POS_W-1:0] scan_row_next;
    logic [POS_W-1:0] x_reg;
    logic [POS_W-1:0] y_reg;

    logic [CNT_W-1:0] c0;
    logic [CNT_W-1:0] r0;
    logic [CNT_W-1:0] cx;
    logic [CNT_W-1:0] r1;
    logic [CNT_W-1:0] ry;
    logic [CNT_W-1:0] cn;
    logic [CNT_W-1:0] rn;

    always_comb
    begin
        c0 = restart ? '0 : {1'b0, scan_col_reg};
        r0 = restart ? '0 : {1'b0, scan_row_reg};
        // stale column past a shrunk width wraps to the next row
        if (c0 >= w_eff)
        begin
            cx = '0;
            r1 = r0 + CNT_W'(1);
        end
        else
        begin
            cx = c0;
            r1 = r0;
        end
        ry = (r1 >= h_eff) ? '0 : r1;

        cn = cx + CNT_W'(1);
        rn = ry + CNT_W'(1);
        if (cn >= w_eff)
        begin
            scan_col_next = '0;
            scan_row_next = (rn >= h_eff) ? '0 : POS_W'(rn);
        end
        else
        begin
            scan_col_next = POS_W'(cn);
            scan_row_next = POS_W'(ry);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
        end
        else if (load)
        begin
            scan_col_reg <= scan_col_next;
            scan_row_reg <= scan_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= POS_W'(cx);
            y_reg <= POS_W'(ry);
        end
    end

    assign x = x_reg;
    assign y = y_reg;

    `RPR_ASSERT_NEXT(a_pos_in_frame, load, (CNT_W'(x) < w_eff) && (CNT_W'(y) < h_eff))

endmodule

`default_nettype wire

// ===== rtl/core/rpr_offset.sv =====
// Offset stage: distance from the inner box, edge proximity and end of frame.
`default_nettype none

module rpr_offset #(
    parameter int POS_W = 11,
    parameter int OFF_W = 14
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [POS_W-1:0]              x_in,
    input  logic [POS_W-1:0]              y_in,
    input  logic [POS_W:0]                w_eff,
    input  logic [POS_W:0]                h_eff,
    input  logic [rpr_pkg::RADIUS_W-1:0]  radius,
    input  logic [rpr_pkg::BORDER_W-1:0]  border,
    output logic [OFF_W-1:0]              adx,
    output logic [OFF_W-1:0]              ady,
    output rpr_pkg::pix_flags_t           flags,
    output logic [POS_W-1:0]              x,
    output logic [POS_W-1:0]              y
);
    import rpr_pkg::*;

    localparam int CNT_W  = POS_W + 1;
    localparam int HALF_W = OFF_W + 1;
    localparam int EW     = ((CNT_W > BORDER_W) ? CNT_W : BORDER_W) + 1;

    // offset of v from the box [lo, hi]; lo wins on an empty box
    function automatic logic signed [HALF_W-1:0] box_off(
        input logic signed [HALF_W-1:0] v,
        input logic signed [HALF_W-1:0] lo,
        input logic signed [HALF_W-1:0] hi
    );
        logic signed [HALF_W-1:0] n;
        n = (v < hi) ? v : hi;
        if (n < lo)
        begin
            n = lo;
        end
        return v - n;
    endfunction

    logic signed [HALF_W-1:0] r_s;
    logic signed [HALF_W-1:0] hx;
    logic signed [HALF_W-1:0] hy;
    logic signed [HALF_W-1:0] vx;
    logic signed [HALF_W-1:0] vy;
    logic signed [HALF_W-1:0] dx;
    logic signed [HALF_W-1:0] dy;
    logic [EW-1:0]            xe;
    logic [EW-1:0]            ye;
    logic [EW-1:0]            be;
    logic [EW-1:0]            we;
    logic [EW-1:0]            he;
    pix_flags_t               flags_next;

    logic [OFF_W-1:0] adx_reg;
    logic [OFF_W-1:0] ady_reg;
    pix_flags_t       flags_reg;
    logic [POS_W-1:0] x_reg;
    logic [POS_W-1:0] y_reg;

    always_comb
    begin
        r_s = $signed(HALF_W'(radius));
        hx  = $signed(HALF_W'({w_eff, 1'b0})) - r_s;
        hy  = $signed(HALF_W'({h_eff, 1'b0})) - r_s;
        vx  = $signed(HALF_W'({x_in, 1'b1}));
        vy  = $signed(HALF_W'({y_in, 1'b1}));
        dx  = box_off(vx, r_s, hx);
        dy  = box_off(vy, r_s, hy);

        xe = EW'(x_in);
        ye = EW'(y_in);
        be = EW'(border);
        we = EW'(w_eff);
        he = EW'(h_eff);

        flags_next.dx_zero   = (dx == '0);
        flags_next.dy_zero   = (dy == '0);
        // x >= w - b written as x + b >= w to stay unsigned
        flags_next.near_edge = (border != '0) &&
                               ((xe < be) || (xe + be >= we) ||
                                (ye < be) || (ye + be >= he));
        flags_next.last      = (CNT_W'(x_in) + CNT_W'(1) == w_eff) &&
                               (CNT_W'(y_in) + CNT_W'(1) == h_eff);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            adx_reg   <= dx[HALF_W-1] ? OFF_W'(-dx) : OFF_W'(dx);
            ady_reg   <= dy[HALF_W-1] ? OFF_W'(-dy) : OFF_W'(dy);
            flags_reg <= flags_next;
            x_reg     <= x_in;
            y_reg     <= y_in;
        end
    end

    assign adx   = adx_reg;
    assign ady   = ady_reg;
    assign flags = flags_reg;
    assign x     = x_reg;
    assign y     = y_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rpr_shade.sv =====
// Shade stages: squared distances, corner test, color select and output register.
`default_nettype none

module rpr_shade #(
    parameter int POS_W = 11,
    parameter int OFF_W = 14
) (
    input  logic                          clk,
    input  logic                          load3,
    input  logic                          load4,
    input  logic [OFF_W-1:0]              adx,
    input  logic [OFF_W-1:0]              ady,
    input  rpr_pkg::pix_flags_t           flags_in,
    input  logic [POS_W-1:0]              x_in,
    input  logic [POS_W-1:0]              y_in,
    input  logic [rpr_pkg::RADIUS_W-1:0]  radius,
    input  logic [rpr_pkg::RGB_W-1:0]     fill_rgb,
    input  logic [rpr_pkg::RGB_W-1:0]     border_rgb,
    output logic [POS_W-1:0]              col,
    output logic [POS_W-1:0]              row,
    output logic [rpr_pkg::CH_W-1:0]      red,
    output logic [rpr_pkg::CH_W-1:0]      green,
    output logic [rpr_pkg::CH_W-1:0]      blue,
    output logic [rpr_pkg::CH_W-1:0]      alpha,
    output logic                          last
);
    import rpr_pkg::*;

    localparam int SQ_W  = 2 * OFF_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int RR_W  = 2 * RADIUS_W;
    localparam int CMP_W = (SUM_W > RR_W) ? SUM_W : RR_W;

    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic [RR_W-1:0]  rr_sq_reg;
    pix_flags_t       flags3_reg;
    logic [POS_W-1:0] x3_reg;
    logic [POS_W-1:0] y3_reg;

    logic [SUM_W-1:0] dist_sq;
    logic             in_shape;
    logic [RGB_W-1:0] rgb_next;

    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic [RGB_W-1:0] rgb_reg;
    logic [CH_W-1:0]  alpha_reg;
    logic             last_reg;

    // the user must change radius only while the pipe is empty; the block itself does not enforce this
    always_ff @(posedge clk)
    begin
        rr_sq_reg <= RR_W'(radius) * RR_W'(radius);
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            sqx_reg    <= SQ_W'(adx) * SQ_W'(adx);
            sqy_reg    <= SQ_W'(ady) * SQ_W'(ady);
            flags3_reg <= flags_in;
            x3_reg     <= x_in;
            y3_reg     <= y_in;
        end
    end

    always_comb
    begin
        dist_sq  = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        in_shape = flags3_reg.dx_zero || flags3_reg.dy_zero ||
                   (CMP_W'(dist_sq) <= CMP_W'(rr_sq_reg));
        if (!in_shape)
        begin
            rgb_next = '0;
        end
        else if (flags3_reg.near_edge)
        begin
            rgb_next = border_rgb;
        end
        else
        begin
            rgb_next = fill_rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            col_reg   <= x3_reg;
            row_reg   <= y3_reg;
            rgb_reg   <= rgb_next;
            alpha_reg <= in_shape ? ALPHA_OPAQUE : ALPHA_CLEAR;
            last_reg  <= flags3_reg.last;
        end
    end

    assign col   = col_reg;
    assign row   = row_reg;
    assign red   = rgb_reg[3*CH_W-1:2*CH_W];
    assign green = rgb_reg[2*CH_W-1:CH_W];
    assign blue  = rgb_reg[CH_W-1:0];
    assign alpha = alpha_reg;
    assign last  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rounded_panel_rasterizer.sv =====
// Rounded panel rasterizer top level: config registers, pipeline control, stages.
// A word accepted at the input passes the scan, offset, square and output registers
//   in that order. Throughput: one pixel per cycle while out_stall is low; each of
//   the four stages has its own valid bit and loads whenever it is empty or its
//   successor moves, so bubbles are squeezed out.
// Reset (rst_n low, async): scan position to (0,0), all stages empty, registers to
//   64x64 frame, zero radius, no border, black colors.
`default_nettype none
`include "assert_macros.svh"

module rounded_panel_rasterizer #(
    parameter int MAX_DIM = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [$clog2(MAX_DIM)-1:0]      col,
    output logic [$clog2(MAX_DIM)-1:0]      row,
    output logic [rpr_pkg::CH_W-1:0]        red,
    output logic [rpr_pkg::CH_W-1:0]        green,
    output logic [rpr_pkg::CH_W-1:0]        blue,
    output logic [rpr_pkg::CH_W-1:0]        alpha,
    output logic                            last
);
    import rpr_pkg::*;

    localparam int POS_W  = $clog2(MAX_DIM);
    // counts up to the frame size itself
    localparam int CNT_W  = POS_W + 1;
    localparam int CMP_W  = (DIM_CFG_W > CNT_W) ? DIM_CFG_W : CNT_W;
    // half-pixel offsets: covers twice the frame size and the full radius
    localparam int HALF_W = (((CNT_W + 1) > RADIUS_W) ? (CNT_W + 1) : RADIUS_W) + 1;
    localparam int OFF_W  = HALF_W - 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DIM_CFG_W-1:0] frame_width_reg;
    logic [DIM_CFG_W-1:0] frame_height_reg;
    logic [RADIUS_W-1:0]  radius_half_reg;
    logic [BORDER_W-1:0]  border_px_reg;
    logic [RGB_W-1:0]     fill_rgb_reg;
    logic [RGB_W-1:0]     border_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_DIM_RST;
            frame_height_reg <= FRAME_DIM_RST;
            radius_half_reg  <= '0;
            border_px_reg    <= '0;
            fill_rgb_reg     <= '0;
            border_rgb_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_CFG_W-1:0];
                CFG_RADIUS_HALF:  radius_half_reg  <= cfg_data[RADIUS_W-1:0];
                CFG_BORDER_PX:    border_px_reg    <= cfg_data[BORDER_W-1:0];
                CFG_FILL_RGB:     fill_rgb_reg     <= cfg_data[RGB_W-1:0];
                CFG_BORDER_RGB:   border_rgb_reg   <= cfg_data[RGB_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size: zero reads as one, anything past MAX_DIM as MAX_DIM.
    // Kept combinational so a word right after a register write sees the new size.
    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] h_eff;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (CMP_W'(frame_width_reg) > CMP_W'(MAX_DIM))
        begin
            w_eff = CNT_W'(MAX_DIM);
        end
        else
        begin
            w_eff = CNT_W'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = CNT_W'(1);
        end
        else if (CMP_W'(frame_height_reg) > CMP_W'(MAX_DIM))
        begin
            h_eff = CNT_W'(MAX_DIM);
        end
        else
        begin
            h_eff = CNT_W'(frame_height_reg);
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: stage 1 scan, 2 offsets, 3 squares, 4 output
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;
    logic ready1;
    logic ready2;
    logic ready3;
    logic ready4;
    logic accept;

    assign ready4   = !out_valid_reg || !out_stall;
    assign ready3   = !s3_valid_reg || ready4;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_stall = !ready1;
    assign accept   = in_valid && ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    logic [POS_W-1:0] s1_x;
    logic [POS_W-1:0] s1_y;
    logic [POS_W-1:0] s2_x;
    logic [POS_W-1:0] s2_y;
    logic [OFF_W-1:0] s2_adx;
    logic [OFF_W-1:0] s2_ady;
    pix_flags_t       s2_flags;

    rpr_scan #(
        .POS_W (POS_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .restart (restart),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .x       (s1_x),
        .y       (s1_y)
    );

    rpr_offset #(
        .POS_W (POS_W),
        .OFF_W (OFF_W)
    ) u_offset (
        .clk    (clk),
        .load   (ready2 && s1_valid_reg),
        .x_in   (s1_x),
        .y_in   (s1_y),
        .w_eff  (w_eff),
        .h_eff  (h_eff),
        .radius (radius_half_reg),
        .border (border_px_reg),
        .adx    (s2_adx),
        .ady    (s2_ady),
        .flags  (s2_flags),
        .x      (s2_x),
        .y      (s2_y)
    );

    rpr_shade #(
        .POS_W (POS_W),
        .OFF_W (OFF_W)
    ) u_shade (
        .clk        (clk),
        .load3      (ready3 && s2_valid_reg),
        .load4      (ready4 && s3_valid_reg),
        .adx        (s2_adx),
        .ady        (s2_ady),
        .flags_in   (s2_flags),
        .x_in       (s2_x),
        .y_in       (s2_y),
        .radius     (radius_half_reg),
        .fill_rgb   (fill_rgb_reg),
        .border_rgb (border_rgb_reg),
        .col        (col),
        .row        (row),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .last       (last)
    );

    logic pipe_full;
    logic pix_clear;

    assign pipe_full = s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg;
    assign pix_clear = (alpha == ALPHA_CLEAR) && (red == '0) && (green == '0) &&
                       (blue == '0);

    // Input backs up only when every stage holds a word
    `RPR_ASSERT_IMPL(a_stall_only_when_full, in_stall, pipe_full)
    // A pixel outside the shape is fully transparent black
    `RPR_ASSERT_IMPL(a_outside_is_clear, out_valid && (alpha != ALPHA_OPAQUE), pix_clear)

endmodule

`default_nettype wire

// ===== bench/rounded_panel_rasterizer_test.sv =====
// Self-checking bench for the rounded panel rasterizer: directed cases and random panels.
`timescale 1ns / 1ps

module rounded_panel_rasterizer_test;
    import rpr_pkg::*;

    localparam int FRAME_MAX   = 2048;
    localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int SETTLE_CYC  = 8;     // pipe is 4 deep; settle time after draining
    localparam int RANDOM_GOAL = 1600;
    localparam int STREAM_LEN  = 300;

    // Indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic [10:0]     col;
        logic [10:0]     row;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last;
    } pixel_t;

    // Block inputs, all known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  restart = 1'b0;
    logic                  out_stall = 1'b0;

    // Block outputs
    logic            in_stall;
    logic            out_valid;
    logic [10:0]     col;
    logic [10:0]     row;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;

    // Shadow of the register file, written alongside every config write
    logic [DIM_CFG_W-1:0] width_reg = FRAME_DIM_RST;
    logic [DIM_CFG_W-1:0] height_reg = FRAME_DIM_RST;
    logic [RADIUS_W-1:0]  radius_reg = '0;
    logic [BORDER_W-1:0]  border_reg = '0;
    logic [RGB_W-1:0]     fill_reg = '0;
    logic [RGB_W-1:0]     edge_rgb_reg = '0;

    // Shadow scan position: next pixel the block will emit
    longint scan_x = 0;
    longint scan_y = 0;

    pixel_t pending_pixels[$];
    int     mismatch_count = 0;
    int     pixels_seen = 0;
    int     words_sent = 0;
    int     quiet_cycles = 0;
    bit     gap_enable = 1'b1;    // sender may insert idle cycles
    bit     stall_enable = 1'b1;  // receiver may stall

    rounded_panel_rasterizer #(.MAX_DIM(FRAME_MAX)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .col       (col),
        .row       (row),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .last      (last)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    // Zero size reads as one pixel, anything past the maximum as the maximum
    function automatic longint clamp_dim(input logic [DIM_CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > FRAME_MAX)
            return FRAME_MAX;
        return v;
    endfunction

    // Distance of a half-pixel coordinate from [lo, hi]; lo wins on an empty box
    function automatic longint inner_box_gap(input longint v, input longint lo,
                                             input longint hi);
        longint n;
        n = (v < hi) ? v : hi;
        if (n < lo)
            n = lo;
        return v - n;
    endfunction

    // Emits the pixel at the scan position and steps the scan in raster order
    function automatic pixel_t raster_pixel(input bit rs);
        longint w, h, x, y, rr, dx, dy, b;
        bit in_shape, near_edge;
        logic [RGB_W-1:0] rgb;
        pixel_t p;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (rs)
        begin
            scan_x = 0;
            scan_y = 0;
        end
        // Frame may have shrunk under the scan position
        if (scan_x >= w)
        begin
            scan_x = 0;
            scan_y++;
        end
        if (scan_y >= h)
            scan_y = 0;
        x = scan_x;
        y = scan_y;

        // Pixel centre is (2x+1, 2y+1) in half-pixel units
        rr = radius_reg;
        dx = inner_box_gap(2 * x + 1, rr, 2 * w - rr);
        dy = inner_box_gap(2 * y + 1, rr, 2 * h - rr);
        in_shape = (dx == 0) || (dy == 0) || (dx * dx + dy * dy <= rr * rr);

        b = border_reg;
        near_edge = (b > 0) && (x < b || x >= w - b || y < b || y >= h - b);
        if (!in_shape)
            rgb = '0;
        else if (near_edge)
            rgb = edge_rgb_reg;
        else
            rgb = fill_reg;

        p.col   = 11'(x);
        p.row   = 11'(y);
        p.red   = rgb[23:16];
        p.green = rgb[15:8];
        p.blue  = rgb[7:0];
        p.alpha = in_shape ? ALPHA_OPAQUE : ALPHA_CLEAR;
        p.last  = (x == w - 1) && (y == h - 1);

        scan_x = x + 1;
        scan_y = y;
        if (scan_x >= w)
        begin
            scan_x = 0;
            scan_y = y + 1;
            if (scan_y >= h)
                scan_y = 0;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Monitors, checker and watchdog (all sample at the rising edge)
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("pixel %0d %s: got 0x%0h, want 0x%0h",
                                      pixels_seen, name, got, want));
    endtask

    // Each accepted input word predicts exactly one pixel
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_pixels.push_back(raster_pixel(restart));
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("pixel (%0d,%0d) with nothing pending", col, row));
            else
            begin
                want = pending_pixels.pop_front();
                check_field("col", col, want.col);
                check_field("row", row, want.row);
                check_field("red", red, want.red);
                check_field("green", green, want.green);
                check_field("blue", blue, want.blue);
                check_field("alpha", alpha, want.alpha);
                check_field("last", last, want.last);
            end
            pixels_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: %0d cycles with no word moving", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge
    always @(negedge clk)
        out_stall = stall_enable && ($urandom_range(99) < 13);

    // ------------------------------------------------------------------
    // Driver tasks; each is entered and left just after a falling edge
    // ------------------------------------------------------------------

    // One input word; random idle cycles ahead of it, held until accepted
    task automatic send_word(input bit rs);
        while (gap_enable && $urandom_range(99) < 13)
        begin
            in_valid = 1'b0;
            restart  = 1'($urandom);  // payload is don't-care while idle
            @(negedge clk);
        end
        in_valid = 1'b1;
        restart  = rs;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        words_sent++;
    endtask

    // Sender pauses until every predicted pixel is out
    task automatic hold_for_results();
        in_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    // Drained and settled: safe point for register writes
    task automatic wait_idle();
        hold_for_results();
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  width_reg    = data[DIM_CFG_W-1:0];
            CFG_FRAME_HEIGHT: height_reg   = data[DIM_CFG_W-1:0];
            CFG_RADIUS_HALF:  radius_reg   = data[RADIUS_W-1:0];
            CFG_BORDER_PX:    border_reg   = data[BORDER_W-1:0];
            CFG_FILL_RGB:     fill_reg     = data[RGB_W-1:0];
            CFG_BORDER_RGB:   edge_rgb_reg = data[RGB_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly tiny frames so the scan wraps often; extremes now and then
    function automatic logic [DIM_CFG_W-1:0] pick_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return DIM_CFG_W'(FRAME_MAX);
            2: return '1;
            3: return DIM_CFG_W'($urandom);
            default: return DIM_CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Random setting; unused upper data bits carry junk that must be dropped
    task automatic randomize_panel();
        logic [DIM_CFG_W-1:0] w, h;
        logic [BORDER_W-1:0]  bpx;
        logic [RADIUS_W-1:0]  rad;
        longint span;
        w = pick_dim();
        h = pick_dim();
        span = 2 * ((clamp_dim(w) > clamp_dim(h)) ? clamp_dim(w) : clamp_dim(h)) + 2;
        case ($urandom_range(9))
            0: rad = '0;
            1: rad = '1;
            2: rad = RADIUS_W'($urandom);
            default: rad = RADIUS_W'($urandom_range(0, 32'(span)));
        endcase
        case ($urandom_range(7))
            0: bpx = '0;
            1: bpx = '1;
            2: bpx = BORDER_W'($urandom);
            default: bpx = BORDER_W'($urandom_range(0, 4));
        endcase
        if ($urandom_range(3) != 0)
            write_reg(CFG_FRAME_WIDTH, {12'($urandom), w});
        if ($urandom_range(3) != 0)
            write_reg(CFG_FRAME_HEIGHT, {12'($urandom), h});
        if ($urandom_range(3) != 0)
            write_reg(CFG_RADIUS_HALF, {11'($urandom), rad});
        if ($urandom_range(3) != 0)
            write_reg(CFG_BORDER_PX, {12'($urandom), bpx});
        if ($urandom_range(3) != 0)
            write_reg(CFG_FILL_RGB, 24'($urandom));
        if ($urandom_range(3) != 0)
            write_reg(CFG_BORDER_RGB, 24'($urandom));
        if ($urandom_range(5) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 24'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 64x64, square corners, black fill: opaque black pixels in raster order, then a restart
    task automatic test_power_on_defaults();
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
    endtask

    // Zero size reads as 1x1 (every pixel is last); 4095 clamps to 2048
    task automatic test_extreme_sizes();
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '0);
        send_word(1'b0);
        send_word(1'b0);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 24'hFFF);
        write_reg(CFG_FRAME_HEIGHT, 24'hFFF);
        write_reg(CFG_RADIUS_HALF, 24'h1FFF);   // empty inner box; the pixels sent here fall outside
        write_reg(CFG_BORDER_PX, 24'hFFF);
        write_reg(CFG_FILL_RGB, 24'hFFFFFF);
        write_reg(CFG_BORDER_RGB, 24'hFFFFFF);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        write_reg(CFG_RADIUS_HALF, '0);         // square again: all border color
        send_word(1'b0);
    endtask

    // 3x3 with a one-pixel border: only the center gets the fill; then wrap
    task automatic test_small_frame_border();
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 24'd3);
        write_reg(CFG_FRAME_HEIGHT, 24'd3);
        write_reg(CFG_RADIUS_HALF, '0);
        write_reg(CFG_BORDER_PX, 24'd1);
        write_reg(CFG_FILL_RGB, 24'h123456);
        write_reg(CFG_BORDER_RGB, 24'hABCDEF);
        send_word(1'b1);
        repeat (9) send_word(1'b0);
    endtask

    // Corner cut on 8x8, then a radius bigger than half a 2x2 frame
    task automatic test_corner_rounding();
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 24'd8);
        write_reg(CFG_FRAME_HEIGHT, 24'd8);
        write_reg(CFG_RADIUS_HALF, 24'd6);
        write_reg(CFG_BORDER_PX, '0);
        write_reg(CFG_FILL_RGB, 24'h00FF00);
        send_word(1'b1);   // (0,0) falls outside the arc
        send_word(1'b0);
        send_word(1'b0);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 24'd2);
        write_reg(CFG_FRAME_HEIGHT, 24'd2);
        write_reg(CFG_RADIUS_HALF, 24'd5);  // empty inner box, lower bound wins
        send_word(1'b1);
        send_word(1'b0);
    endtask

    // Shrinking the frame under the scan moves it to the next row, then to row 0
    task automatic test_frame_shrink_mid_scan();
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 24'd16);
        write_reg(CFG_FRAME_HEIGHT, 24'd16);
        write_reg(CFG_RADIUS_HALF, '0);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 24'd2);   // column 3 is past the edge
        send_word(1'b0);
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, 24'd1);  // row 1 is past the bottom
        send_word(1'b0);
    endtask

    // Random settings, bursts of raster words with rare restarts
    task automatic test_random_panels();
        int goal, phase, n, hold_at;
        bit calm;
        goal  = words_sent + RANDOM_GOAL;
        phase = 0;
        while (words_sent < goal)
        begin
            wait_idle();
            randomize_panel();
            // Now and then a burst with no idling on either side
            calm = ($urandom_range(7) == 0);
            gap_enable   = !calm;
            stall_enable = !calm;
            n = $urandom_range(20, 120);
            // First burst always, later ones sometimes: stop and drain mid-burst
            hold_at = (phase == 0 || $urandom_range(9) == 0) ? $urandom_range(1, n - 1) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == hold_at)
                    hold_for_results();
                send_word($urandom_range(99) < 5);
            end
            phase++;
        end
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
    endtask

    // Long stretch at full rate, no gaps and no stalls
    task automatic test_back_to_back();
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 24'd7);
        write_reg(CFG_FRAME_HEIGHT, 24'd5);
        write_reg(CFG_RADIUS_HALF, 24'd4);
        write_reg(CFG_BORDER_PX, 24'd1);
        write_reg(CFG_FILL_RGB, 24'($urandom));
        write_reg(CFG_BORDER_RGB, 24'($urandom));
        gap_enable   = 1'b0;
        stall_enable = 1'b0;
        repeat (STREAM_LEN) send_word($urandom_range(99) < 2);
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_power_on_defaults();
        test_extreme_sizes();
        test_small_frame_border();
        test_corner_rounding();
        test_frame_shrink_mid_scan();
        test_random_panels();
        test_back_to_back();

        // Drain, then watch a while longer for stray pixels
        hold_for_results();
        repeat (5 * SETTLE_CYC) @(negedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
